// ===== hdl/hrr_pkg.sv =====
package hrr_pkg;

   // default packet store size in bytes
   localparam int PACKET_BUFFER_BYTES_DEF = 1024;

   // fragment staging store
   localparam int STAGE_DEPTH = 64;
   localparam int STAGE_AW    = $clog2(STAGE_DEPTH);

   // byte position saturates here, so overlong reports come out malformed
   localparam logic [6:0] POS_MAX = 7'd127;

   // link control byte bits
   localparam int LINK_CONTINUE_BIT = 0;
   localparam int LINK_MORE_BIT     = 1;

   // report id and size table; a size counts the link control byte
   localparam int NUM_IDS = 5;
   localparam logic [7:0] ID_TABLE [NUM_IDS] = '{8'h05, 8'h06, 8'h07, 8'h08, 8'h09};
   localparam logic [7:0] SIZE_TABLE [NUM_IDS] = '{8'h08, 8'h0A, 8'h0E, 8'h14, 8'h3F};

   typedef enum logic [2:0] {
      ST_FRAGMENT  = 3'd0,
      ST_COMPLETE  = 3'd1,
      ST_MALFORMED = 3'd2,
      ST_OVERFLOW  = 3'd3,
      ST_ORPHAN    = 3'd4,
      ST_READ      = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_READ,
      S_COPY,
      S_DRAIN
   } state_type;

   // size listed for a report id, zero when the id is unknown
   function automatic logic [7:0] lookup_size(input logic [7:0] id);
      logic [7:0] size;
      size = 8'd0;
      for (int i = 0; i < NUM_IDS; i++) begin
         if (ID_TABLE[i] == id) begin
            size = SIZE_TABLE[i];
         end
      end
      return size;
   endfunction

endpackage

// ===== hdl/hrr_req_if.sv =====
interface hrr_req_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] report_byte;
   logic       end_of_report;
   logic [9:0] read_address;

   modport source (output valid, output kind, output report_byte, output end_of_report,
                   output read_address, input ready);
   modport sink (input valid, input kind, input report_byte, input end_of_report,
                 input read_address, output ready);
endinterface

// ===== hdl/hrr_rsp_if.sv =====
interface hrr_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [10:0] packet_length;
   logic [7:0]  read_data;
   logic        discarded_partial;

   modport source (output valid, output status, output packet_length, output read_data,
                   output discarded_partial, input ready);
   modport sink (input valid, input status, input packet_length, input read_data,
                 input discarded_partial, output ready);
endinterface

// ===== hdl/hrr_ram.sv =====
module hrr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/hid_report_reassembler.sv =====
// channel   dir  handshake     word
// req_ch    in   valid/ready   kind, report_byte, end_of_report, read_address
// rsp_ch    out  valid/ready   status, packet_length, read_data, discarded_partial
//
// A report byte that does not end a report gives no word.
// A read passes through the packet store read port, then the result register.
// A valid report end copies its payload from the staging RAM to the packet store,
// one byte a cycle through the staging read port.
// Reset is synchronous and clears control state only; both RAMs start undefined.
// req_ch.ready is low during a read or copy, and while a result word waits.
module hid_report_reassembler
   import hrr_pkg::*;
#(
   parameter int PACKET_BUFFER_BYTES = PACKET_BUFFER_BYTES_DEF
) (
   input  logic clock,
   input  logic reset,
   hrr_req_if.sink   req_ch,
   hrr_rsp_if.source rsp_ch
);

   localparam int AW = $clog2(PACKET_BUFFER_BYTES);     // store address
   localparam int CW = $clog2(PACKET_BUFFER_BYTES + 1); // cursor, holds the size itself
   localparam int LW = CW + 1;                          // cursor plus payload
   localparam int RW = (CW > 10) ? CW : 10;             // read address compare

   // control registers
   state_type           state_ff, state_in;
   logic [6:0]          pos_ff, pos_in;
   logic [CW-1:0]       cursor_ff, cursor_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // payload registers
   logic [7:0]          id_ff, id_in;
   logic [7:0]          link_ff, link_in;
   logic [CW-1:0]       base_ff, base_in;
   logic [5:0]          payload_ff, payload_in;
   logic                more_ff, more_in;
   logic                disc_ff, disc_in;
   logic [5:0]          issue_ff, issue_in;
   logic                wr_valid_ff, wr_valid_in;
   logic [5:0]          wr_idx_ff, wr_idx_in;
   logic                rng_ff, rng_in;
   status_type          rsp_status_ff, rsp_status_in;
   logic [10:0]         rsp_len_ff, rsp_len_in;
   logic [7:0]          rsp_rdata_ff, rsp_rdata_in;
   logic                rsp_disc_ff, rsp_disc_in;

   // handshake and datapath
   logic                ready;
   logic                accept;
   logic [7:0]          eff_id;
   logic [7:0]          eff_link;
   logic [7:0]          rsize;
   logic [LW-1:0]       commit_end;
   logic [LW-1:0]       final_end;
   logic [RW-1:0]       ra_ext;

   // RAM ports
   logic                stage_we;
   logic [STAGE_AW-1:0] stage_waddr;
   logic [7:0]          stage_rdata;
   logic [AW-1:0]       store_waddr;
   logic [7:0]          store_rdata;

   assign ready  = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ch.ready);
   assign accept = req_ch.valid && ready;

   // id and link byte may arrive on the very byte that ends the report
   assign eff_id   = (pos_ff == 7'd0) ? req_ch.report_byte : id_ff;
   assign eff_link = (pos_ff == 7'd1) ? req_ch.report_byte : link_ff;
   assign rsize    = lookup_size(eff_id);

   assign commit_end = LW'(cursor_ff) + LW'(payload_in);
   assign final_end  = LW'(base_ff) + LW'(payload_ff);
   assign ra_ext     = RW'(req_ch.read_address);

   // staging writes for payload positions only
   assign stage_we    = accept && !req_ch.kind && (pos_ff >= 7'd2) &&
                        (pos_ff < 7'(STAGE_DEPTH + 2));
   assign stage_waddr = STAGE_AW'(pos_ff - 7'd2);

   // store written in the cycle after each staging read
   assign store_waddr = AW'(LW'(base_ff) + LW'(wr_idx_ff));

   hrr_ram #(
      .WIDTH (8),
      .DEPTH (STAGE_DEPTH)
   ) u_stage (
      .clock   (clock),
      .wr_en   (stage_we),
      .wr_addr (stage_waddr),
      .wr_data (req_ch.report_byte),
      .rd_addr (issue_ff),
      .rd_data (stage_rdata)
   );

   // reads happen only when idle and writes only during a copy, so no overlap
   hrr_ram #(
      .WIDTH (8),
      .DEPTH (PACKET_BUFFER_BYTES)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_valid_ff),
      .wr_addr (store_waddr),
      .wr_data (stage_rdata),
      .rd_addr (ra_ext[AW-1:0]),
      .rd_data (store_rdata)
   );

   // next state and outputs
   always_comb begin
      state_in      = state_ff;
      pos_in        = pos_ff;
      cursor_in     = cursor_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      id_in         = id_ff;
      link_in       = link_ff;
      base_in       = base_ff;
      payload_in    = 6'(rsize - 8'd1);
      more_in       = more_ff;
      disc_in       = disc_ff;
      issue_in      = issue_ff;
      wr_valid_in   = 1'b0;
      wr_idx_in     = wr_idx_ff;
      rng_in        = rng_ff;
      rsp_status_in = rsp_status_ff;
      rsp_len_in    = rsp_len_ff;
      rsp_rdata_in  = rsp_rdata_ff;
      rsp_disc_in   = rsp_disc_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept && req_ch.kind) begin
               rng_in   = ra_ext < RW'(PACKET_BUFFER_BYTES);
               state_in = S_READ;
            end else if (accept) begin
               id_in   = eff_id;
               link_in = eff_link;
               if (!req_ch.end_of_report) begin
                  pos_in = (pos_ff < POS_MAX) ? pos_ff + 7'd1 : POS_MAX;
               end else begin
                  pos_in       = 7'd0;
                  rsp_len_in   = 11'd0;
                  rsp_rdata_in = 8'd0;
                  rsp_disc_in  = 1'b0;
                  if (rsize == 8'd0 || pos_ff != rsize[6:0]) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = ST_MALFORMED;
                  end else if (commit_end > LW'(PACKET_BUFFER_BYTES)) begin
                     cursor_in     = '0;
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = ST_OVERFLOW;
                  end else if (eff_link[LINK_CONTINUE_BIT] && cursor_ff == '0) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = ST_ORPHAN;
                  end else begin
                     // first fragment starts over; continuation appends
                     base_in  = eff_link[LINK_CONTINUE_BIT] ? cursor_ff : '0;
                     disc_in  = !eff_link[LINK_CONTINUE_BIT] && (cursor_ff != '0);
                     more_in  = eff_link[LINK_MORE_BIT];
                     issue_in = 6'd0;
                     state_in = S_COPY;
                  end
               end
            end
         end
         S_READ: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = ST_READ;
            rsp_len_in    = 11'd0;
            rsp_rdata_in  = rng_ff ? store_rdata : 8'd0;
            rsp_disc_in   = 1'b0;
            state_in      = S_IDLE;
         end
         S_COPY: begin
            // staging read now, store write next cycle
            payload_in  = payload_ff;
            wr_valid_in = 1'b1;
            wr_idx_in   = issue_ff;
            issue_in    = issue_ff + 6'd1;
            if (issue_ff == payload_ff - 6'd1) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            // last store write goes out this cycle
            payload_in   = payload_ff;
            rsp_valid_in = 1'b1;
            rsp_rdata_in = 8'd0;
            rsp_disc_in  = disc_ff;
            if (!more_ff) begin
               cursor_in     = '0;
               rsp_status_in = ST_COMPLETE;
               rsp_len_in    = 11'(final_end);
            end else begin
               cursor_in     = CW'(final_end);
               rsp_status_in = ST_FRAGMENT;
               rsp_len_in    = 11'd0;
            end
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pos_ff       <= 7'd0;
         cursor_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         wr_valid_ff  <= 1'b0;
         id_ff        <= 8'd0;
         link_ff      <= 8'd0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         cursor_ff    <= cursor_in;
         rsp_valid_ff <= rsp_valid_in;
         wr_valid_ff  <= wr_valid_in;
         id_ff        <= id_in;
         link_ff      <= link_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      base_ff       <= base_in;
      payload_ff    <= payload_in;
      more_ff       <= more_in;
      disc_ff       <= disc_in;
      issue_ff      <= issue_in;
      wr_idx_ff     <= wr_idx_in;
      rng_ff        <= rng_in;
      rsp_status_ff <= rsp_status_in;
      rsp_len_ff    <= rsp_len_in;
      rsp_rdata_ff  <= rsp_rdata_in;
      rsp_disc_ff   <= rsp_disc_in;
   end

   assign req_ch.ready             = ready;
   assign rsp_ch.valid             = rsp_valid_ff;
   assign rsp_ch.status            = rsp_status_ff;
   assign rsp_ch.packet_length     = rsp_len_ff;
   assign rsp_ch.read_data         = rsp_rdata_ff;
   assign rsp_ch.discarded_partial = rsp_disc_ff;

endmodule
